@@ rtl/ide_pkg.sv @@
// Shared constants and types for the integer radix digit emitter.
`timescale 1ns / 1ps
`default_nettype none

package ide_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int RADIX_W         = 4;
  localparam int RADIX_MIN       = 2;
  localparam int RADIX_MAX       = 10;
  localparam int RADIX_RESET     = 8;
  localparam int DIGIT_W         = 4;
  localparam int STACK_CAP       = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int DIV_BITS        = 8;

  typedef enum logic [1:0] {
    KIND_CONV,
    KIND_ZERO,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [RADIX_W-1:0] radix;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/ide_front.sv @@
// Front end: radix register, item acceptance and classification.
`timescale 1ns / 1ps
`default_nettype none

module ide_front
  import ide_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  input  wire logic                   cfg_we,
  input  wire logic [RADIX_W-1:0]     cfg_wdata,
  input  wire logic                   q_full,
  output logic                        busy,
  output logic                        q_push,
  output cmd_t                        q_cmd,
  output logic [VALUE_WIDTH-1:0]      q_value
);

  logic [RADIX_W-1:0] radix_r;
  logic [RADIX_W-1:0] radix_nxt;
  logic               radix_bad;

  always_comb begin
    radix_nxt = radix_r;
    if (cfg_we) begin
      radix_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_W'(RADIX_RESET);
    end else begin
      radix_r <= radix_nxt;
    end
  end

  assign radix_bad = (radix_r < RADIX_W'(RADIX_MIN)) || (radix_r > RADIX_W'(RADIX_MAX));

  assign busy    = q_full;
  assign q_push  = start && !q_full;
  assign q_value = in_value;

  always_comb begin
    q_cmd.radix = radix_r;
    priority if (radix_bad) begin
      q_cmd.kind = KIND_BAD;
    end else if (in_value == '0) begin
      q_cmd.kind = KIND_ZERO;
    end else begin
      q_cmd.kind = KIND_CONV;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ide_queue.sv @@
// Short item queue between the front end and the conversion engine.
`timescale 1ns / 1ps
`default_nettype none

module ide_queue
  import ide_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire cmd_t                   push_cmd,
  input  wire logic [VALUE_WIDTH-1:0] push_value,
  input  wire logic                   pop,
  output cmd_t                        head_cmd,
  output logic [VALUE_WIDTH-1:0]      head_value,
  output logic                        full,
  output logic                        empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t                   cmd_q   [QUEUE_DEPTH];
  logic [VALUE_WIDTH-1:0] value_q [QUEUE_DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty      = (count_r == '0);
  assign head_cmd   = cmd_q[rd_ptr_r];
  assign head_value = value_q[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q[wr_ptr_r]   <= push_cmd;
      value_q[wr_ptr_r] <= push_value;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ide_back.sv @@
// Conversion engine: iterative division, digit stack and digit emission.
`timescale 1ns / 1ps
`default_nettype none

module ide_back
  import ide_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_empty,
  input  wire cmd_t                   q_cmd,
  input  wire logic [VALUE_WIDTH-1:0] q_value,
  output logic                        q_pop,
  output logic                        out_strobe,
  output logic [DIGIT_W-1:0]          out_digit,
  output logic                        out_digit_valid,
  output logic                        out_error,
  output logic                        out_last
);

  localparam int DIV_CYC = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int PAD_W   = DIV_CYC * DIV_BITS;
  localparam int CNT_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
  localparam int SP_W    = $clog2(STACK_CAP);
  localparam int DEPTH_W = SP_W + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;

  logic [1:0]         state_r,  state_nxt;
  logic [PAD_W-1:0]   quot_r,   quot_nxt;
  logic [RADIX_W-1:0] rem_r,    rem_nxt;
  logic [RADIX_W-1:0] radix_r,  radix_nxt;
  logic [CNT_W-1:0]   cnt_r,    cnt_nxt;
  logic [DEPTH_W-1:0] depth_r,  depth_nxt;

  logic [PAD_W-1:0]   step_quot;
  logic [RADIX_W-1:0] step_rem;
  logic               step_done;

  logic               push_en;
  logic               pop_en;
  logic [SP_W-1:0]    rd_addr;
  logic [DEPTH_W-1:0] depth_dec;

  logic               spec_en;
  logic               spec_err;

  logic [DIGIT_W-1:0] stack_mem [STACK_CAP];
  logic [DIGIT_W-1:0] rd_q_r;

  logic out_strobe_r, out_strobe_nxt;
  logic out_valid_r,  out_valid_nxt;
  logic out_error_r,  out_error_nxt;
  logic out_last_r,   out_last_nxt;

  // Eight restoring steps per cycle on the top byte of the dividend.
  always_comb begin
    logic [RADIX_W-1:0]  rem;
    logic [RADIX_W:0]    trial;
    logic [DIV_BITS-1:0] chunk;
    logic [DIV_BITS-1:0] qbits;
    rem   = rem_r;
    chunk = quot_r[PAD_W-1 -: DIV_BITS];
    qbits = '0;
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      trial = {rem, chunk[i]};
      if (trial >= {1'b0, radix_r}) begin
        trial    = trial - {1'b0, radix_r};
        qbits[i] = 1'b1;
      end
      rem = trial[RADIX_W-1:0];
    end
    step_rem  = rem;
    step_quot = (quot_r << DIV_BITS) | PAD_W'(qbits);
  end

  assign step_done = (cnt_r == CNT_W'(DIV_CYC - 1));
  assign depth_dec = depth_r - 1'b1;
  assign rd_addr   = depth_dec[SP_W-1:0];

  always_comb begin
    state_nxt = state_r;
    quot_nxt  = quot_r;
    rem_nxt   = rem_r;
    radix_nxt = radix_r;
    cnt_nxt   = cnt_r;
    depth_nxt = depth_r;
    q_pop     = 1'b0;
    push_en   = 1'b0;
    pop_en    = 1'b0;
    spec_en   = 1'b0;
    spec_err  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            KIND_CONV: begin
              quot_nxt  = PAD_W'(q_value);
              rem_nxt   = '0;
              radix_nxt = q_cmd.radix;
              cnt_nxt   = '0;
              depth_nxt = '0;
              state_nxt = ST_DIV;
            end
            KIND_ZERO: begin
              spec_en = 1'b1;
            end
            default: begin
              spec_en  = 1'b1;
              spec_err = 1'b1;
            end
          endcase
        end
      end
      ST_DIV: begin
        quot_nxt = step_quot;
        rem_nxt  = step_rem;
        cnt_nxt  = cnt_r + 1'b1;
        if (step_done) begin
          // Drop digits beyond the stack capacity.
          if (depth_r < DEPTH_W'(STACK_CAP)) begin
            push_en   = 1'b1;
            depth_nxt = depth_r + 1'b1;
          end
          rem_nxt = '0;
          cnt_nxt = '0;
          if (step_quot == '0) begin
            state_nxt = ST_POP;
          end
        end
      end
      ST_POP: begin
        pop_en    = 1'b1;
        depth_nxt = depth_dec;
        if (depth_dec == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      depth_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r  <= quot_nxt;
    rem_r   <= rem_nxt;
    radix_r <= radix_nxt;
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_mem[depth_r[SP_W-1:0]] <= step_rem;
    end
    if (pop_en) begin
      rd_q_r <= stack_mem[rd_addr];
    end
  end

  always_comb begin
    out_strobe_nxt = pop_en || spec_en;
    out_valid_nxt  = pop_en;
    out_error_nxt  = spec_err;
    out_last_nxt   = spec_en || (depth_dec == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_valid_r <= out_valid_nxt;
    out_error_r <= out_error_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_digit       = out_valid_r ? rd_q_r : '0;
  assign out_digit_valid = out_valid_r;
  assign out_error       = out_error_r;
  assign out_last        = out_last_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(STACK_CAP))
    else $error("digit stack depth exceeds capacity");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |-> (depth_r != '0))
    else $error("pop from empty digit stack");

  a_last_digit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_valid_r && out_last_r) |-> (state_r == ST_IDLE))
    else $error("engine still active after final digit");

  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_error_r) |-> (out_last_r && !out_valid_r))
    else $error("error result not a lone final result");

endmodule

`default_nettype wire

@@ rtl/integer_radix_digit_emitter.sv @@
// Top level of the integer radix digit emitter.
//
// Usage:
//   Write the radix through cfg_we / cfg_wdata while the block is idle; it
//   resets to 8. Only radix 2..10 converts; any other radix gives one result
//   with out_error and out_last set.
//   Present an item on in_value and raise start; it is taken at a clock edge
//   where start is high and busy is low. Up to two items wait in the queue
//   behind the engine; busy is high only while that queue is full.
//   Results come one per out_strobe pulse, most significant digit first, the
//   final one with out_last. A zero item gives one result with out_last and
//   no valid digit. The receiver cannot stall: each result shows for one cycle.
// Engine operation:
//   Each digit comes from the divide unit, a byte of the dividend at a time
//   (8 restoring steps per cycle); digits then leave the stack one per cycle.
//   The engine takes a new item from the queue only when idle, after the
//   last digit of the previous one. Error and zero items are answered from
//   the idle state without division. The first digit is read in the pop
//   state after the last divide step, through a registered output.
// Reset: synchronous, active low; clears the queue and the engine and sets the radix to 8.
`timescale 1ns / 1ps
`default_nettype none

module integer_radix_digit_emitter
  import ide_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  input  wire logic                   cfg_we,
  input  wire logic [RADIX_W-1:0]     cfg_wdata,
  output logic                        out_strobe,
  output logic [DIGIT_W-1:0]          out_digit,
  output logic                        out_digit_valid,
  output logic                        out_error,
  output logic                        out_last
);

  // Front to queue.
  logic                   q_push;
  cmd_t                   push_cmd;
  logic [VALUE_WIDTH-1:0] push_value;
  logic                   q_full;

  // Queue to engine.
  logic                   q_pop;
  logic                   q_empty;
  cmd_t                   head_cmd;
  logic [VALUE_WIDTH-1:0] head_value;

  // Accept and classify each item against the current radix.
  ide_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_value  (in_value),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .busy      (busy),
    .q_push    (q_push),
    .q_cmd     (push_cmd),
    .q_value   (push_value)
  );

  // Hold classified items while the engine works on an earlier one.
  ide_queue #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .push_value (push_value),
    .pop        (q_pop),
    .head_cmd   (head_cmd),
    .head_value (head_value),
    .full       (q_full),
    .empty      (q_empty)
  );

  // Divide, stack the remainders, then emit them most significant first.
  ide_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_cmd           (head_cmd),
    .q_value         (head_value),
    .q_pop           (q_pop),
    .out_strobe      (out_strobe),
    .out_digit       (out_digit),
    .out_digit_valid (out_digit_valid),
    .out_error       (out_error),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire
